// File: rtl/core/cfq_pkg.sv
// ----------------------------------------------------------------------------
// cfq_pkg
// Shared sizes, command codes and status types of the circular FIFO queue.
// ----------------------------------------------------------------------------
package cfq_pkg;

  localparam int DEPTH     = 64;
  localparam int WORD_BITS = 32;

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  // Fixed field widths on the ports
  localparam int CMD_BITS  = 3;
  localparam int WORD_FLD  = 32;
  localparam int CNT_FLD   = 7;
  localparam int IN_DATA_W = 48;
  localparam int OUT_DATA_W = 48;

  localparam logic [CMD_BITS-1:0] CMD_PUSH      = 3'd0;
  localparam logic [CMD_BITS-1:0] CMD_POP       = 3'd1;
  localparam logic [CMD_BITS-1:0] CMD_PEEK_HEAD = 3'd2;
  localparam logic [CMD_BITS-1:0] CMD_PEEK_NEW  = 3'd3;
  localparam logic [CMD_BITS-1:0] CMD_CLEAR     = 3'd4;

  typedef struct packed {
    logic             word_vld;  // read_word comes from the RAM
    logic             success;
    logic [CNT_W-1:0] used;
    logic [CNT_W-1:0] free;
    logic             full;
    logic             empty;
    logic             last;
  } out_stat_t;

endpackage

// File: rtl/core/cfq_ram.sv
// ----------------------------------------------------------------------------
// cfq_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module cfq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// File: rtl/core/cfq_ctrl.sv
// ----------------------------------------------------------------------------
// cfq_ctrl
// Pointer and count keeper: decodes commands, drives the slot RAM and
// sequences head peek runs one word per cycle while adv is high.
// ----------------------------------------------------------------------------
module cfq_ctrl (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [cfq_pkg::CNT_FLD-1:0]         cfg_cap,
  input  logic                                cmd_valid,
  output logic                                cmd_ready,
  input  logic [cfq_pkg::CMD_BITS-1:0]        cmd,
  input  logic [cfq_pkg::WORD_BITS-1:0]       wword,
  input  logic [cfq_pkg::CNT_FLD-1:0]         pcount,
  input  logic                                adv,
  output logic                                issue,
  output cfq_pkg::out_stat_t                  stat,
  output logic                                ram_we,
  output logic [cfq_pkg::PTR_W-1:0]           ram_waddr,
  output logic [cfq_pkg::WORD_BITS-1:0]       ram_wdata,
  output logic                                ram_re,
  output logic [cfq_pkg::PTR_W-1:0]           ram_raddr
);
  import cfq_pkg::*;

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_PEEK = 1'b1;

  logic             st_r,     st_nxt;
  logic [CNT_W-1:0] cap_r,    cap_nxt;
  logic [CNT_W-1:0] held_r,   held_nxt;
  logic [PTR_W-1:0] head_r,   head_nxt;
  logic [PTR_W-1:0] tail_r,   tail_nxt;
  logic [PTR_W-1:0] pk_ptr_r, pk_ptr_nxt;
  logic [CNT_W-1:0] rem_r,    rem_nxt;

  logic               acc;
  logic [CNT_FLD-1:0] pc0;
  logic [CNT_FLD-1:0] run_len;

  function automatic logic [PTR_W-1:0] wrap_inc(input logic [PTR_W-1:0] p,
                                                 input logic [CNT_W-1:0] cap);
    logic [CNT_W:0] n;
    n = (CNT_W+1)'(p) + 1'b1;
    return (n >= (CNT_W+1)'(cap)) ? '0 : PTR_W'(n);
  endfunction

  // hold off commands while a capacity write takes the cycle
  assign cmd_ready = (st_r == ST_IDLE) && adv && !cfg_we;
  assign acc       = cmd_valid && cmd_ready;
  assign pc0       = (pcount == '0) ? CNT_FLD'(1) : pcount;
  assign run_len   = (pc0 < CNT_FLD'(held_r)) ? pc0 : CNT_FLD'(held_r);

  always_comb begin
    st_nxt     = st_r;
    cap_nxt    = cap_r;
    held_nxt   = held_r;
    head_nxt   = head_r;
    tail_nxt   = tail_r;
    pk_ptr_nxt = pk_ptr_r;
    rem_nxt    = rem_r;
    issue      = 1'b0;
    ram_we     = 1'b0;
    ram_waddr  = tail_r;
    ram_wdata  = wword;
    ram_re     = 1'b0;
    ram_raddr  = head_r;
    stat       = '0;
    stat.last  = 1'b1;

    if (cfg_we) begin
      // clamp into 1..DEPTH and empty the queue
      if (cfg_cap == '0) begin
        cap_nxt = CNT_W'(1);
      end else if (cfg_cap > CNT_FLD'(DEPTH)) begin
        cap_nxt = CNT_W'(DEPTH);
      end else begin
        cap_nxt = CNT_W'(cfg_cap);
      end
      held_nxt = '0;
      head_nxt = '0;
      tail_nxt = '0;
    end else if (acc) begin
      issue = 1'b1;
      unique case (cmd)
        CMD_PUSH: begin
          if (held_r < cap_r) begin
            ram_we       = 1'b1;
            tail_nxt     = wrap_inc(tail_r, cap_r);
            held_nxt     = held_r + 1'b1;
            stat.success = 1'b1;
          end
        end
        CMD_POP: begin
          if (held_r != '0) begin
            ram_re        = 1'b1;
            head_nxt      = wrap_inc(head_r, cap_r);
            held_nxt      = held_r - 1'b1;
            stat.success  = 1'b1;
            stat.word_vld = 1'b1;
          end
        end
        CMD_PEEK_HEAD: begin
          if (held_r != '0) begin
            ram_re        = 1'b1;
            stat.success  = 1'b1;
            stat.word_vld = 1'b1;
            pk_ptr_nxt    = wrap_inc(head_r, cap_r);
            rem_nxt       = CNT_W'(run_len - 1'b1);
            if (run_len != CNT_FLD'(1)) begin
              stat.last = 1'b0;
              st_nxt    = ST_PEEK;
            end
          end
        end
        CMD_PEEK_NEW: begin
          if (held_r != '0) begin
            ram_re        = 1'b1;
            ram_raddr     = (tail_r == '0) ? PTR_W'(cap_r - 1'b1) : tail_r - 1'b1;
            stat.success  = 1'b1;
            stat.word_vld = 1'b1;
          end
        end
        CMD_CLEAR: begin
          held_nxt     = '0;
          head_nxt     = '0;
          tail_nxt     = '0;
          stat.success = 1'b1;
        end
        default: begin
        end
      endcase
    end else if ((st_r == ST_PEEK) && adv) begin
      // continue the head peek run
      issue         = 1'b1;
      ram_re        = 1'b1;
      ram_raddr     = pk_ptr_r;
      stat.success  = 1'b1;
      stat.word_vld = 1'b1;
      pk_ptr_nxt    = wrap_inc(pk_ptr_r, cap_r);
      rem_nxt       = rem_r - 1'b1;
      stat.last     = (rem_r == CNT_W'(1));
      if (rem_r == CNT_W'(1)) begin
        st_nxt = ST_IDLE;
      end
    end

    stat.used  = held_nxt;
    stat.free  = cap_r - held_nxt;
    stat.full  = (held_nxt == cap_r);
    stat.empty = (held_nxt == '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= ST_IDLE;
      cap_r  <= CNT_W'(DEPTH);
      held_r <= '0;
      head_r <= '0;
      tail_r <= '0;
      rem_r  <= '0;
    end else begin
      st_r   <= st_nxt;
      cap_r  <= cap_nxt;
      held_r <= held_nxt;
      head_r <= head_nxt;
      tail_r <= tail_nxt;
      rem_r  <= rem_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pk_ptr_r <= pk_ptr_nxt;
  end

  a_held_le_cap: assert property (@(posedge clk) disable iff (!rst_n)
    held_r <= cap_r)
    else $error("held count above capacity");

  a_head_in_ring: assert property (@(posedge clk) disable iff (!rst_n)
    CNT_W'(head_r) < cap_r && CNT_W'(tail_r) < cap_r)
    else $error("pointer outside configured ring");

  a_push_count: assert property (@(posedge clk) disable iff (!rst_n)
    acc && !cfg_we && cmd == CMD_PUSH && held_r < cap_r |=>
      held_r == $past(held_r) + 1'b1)
    else $error("push did not advance held count");

  a_run_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    st_r == ST_PEEK |-> !cmd_ready && rem_r != '0)
    else $error("new item taken during a peek run");

endmodule

// File: rtl/core/circular_fifo_queue_core.sv
// ----------------------------------------------------------------------------
// circular_fifo_queue_core
// Ring-buffer FIFO of words with push, pop, head peek, newest peek and clear.
// ----------------------------------------------------------------------------
// Usage:
//   in_*   : one command item per handshake (push, pop, peek head run,
//            peek newest, clear).
//   out_*  : result items; every command gives one result except a head
//            peek, which gives one result per word read, tlast on the final.
//   cfg_*  : capacity write (1..64, clamped); always ready, empties the queue.
//            Write it only while no command is in flight.
// Latency: a result is valid the cycle after its command is accepted; the
//   word comes straight from the registered read port of the slot RAM.
// Throughput: one item per cycle for single-result commands while out_tready
//   is high; a head peek of n words holds off new commands until its last
//   read is issued while the sequencer walks the RAM read port one slot a cycle.
// Reset: capacity 64, queue empty; slot contents stay as they were.
// Stall: while a result waits with out_tready low the result register holds,
//   and no new item is accepted and no RAM read is issued.
// ----------------------------------------------------------------------------
module circular_fifo_queue_core (
  input  logic                              clk,
  input  logic                              rst_n,
  // cfg_data: capacity
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [cfq_pkg::CNT_FLD-1:0]       cfg_data,
  // in_tdata: [2:0] command, [34:3] write_word, [41:35] peek_count, rest zero
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [cfq_pkg::IN_DATA_W-1:0]     in_tdata,
  // out_tdata: [31:0] read_word, [38:32] used_count, [45:39] free_count,
  //            [46] is_full, [47] is_empty
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [cfq_pkg::OUT_DATA_W-1:0]    out_tdata,
  // out_tuser: [0] success
  output logic                              out_tuser,
  output logic                              out_tlast
);
  import cfq_pkg::*;

  logic                 issue;
  logic                 adv;
  out_stat_t            stat;
  out_stat_t            stat_r;
  logic                 out_valid_r, out_valid_nxt;
  logic                 ram_we, ram_re;
  logic [PTR_W-1:0]     ram_waddr, ram_raddr;
  logic [WORD_BITS-1:0] ram_wdata, ram_rdata;
  logic [63:0]          word_ext;
  logic [WORD_FLD-1:0]  read_word;

  assign cfg_ready = 1'b1;
  assign adv       = !out_valid_r || out_tready;

  cfq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_valid),
    .cfg_cap   (cfg_data),
    .cmd_valid (in_tvalid),
    .cmd_ready (in_tready),
    .cmd       (in_tdata[2:0]),
    .wword     (WORD_BITS'(in_tdata[34:3])),
    .pcount    (in_tdata[41:35]),
    .adv       (adv),
    .issue     (issue),
    .stat      (stat),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .ram_re    (ram_re),
    .ram_raddr (ram_raddr)
  );

  cfq_ram #(
    .WIDTH (WORD_BITS),
    .DEPTH (DEPTH)
  ) u_slot_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // hold the result until taken; RAM read data holds too since no read issues
  assign out_valid_nxt = issue ? 1'b1 : (out_tready ? 1'b0 : out_valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      stat_r <= stat;
    end
  end

  assign word_ext  = 64'(ram_rdata);
  assign read_word = stat_r.word_vld ? word_ext[WORD_FLD-1:0] : '0;

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {stat_r.empty, stat_r.full,
                       CNT_FLD'(stat_r.free), CNT_FLD'(stat_r.used), read_word};
  assign out_tuser  = stat_r.success;
  assign out_tlast  = stat_r.last;

endmodule

// File: dv/cfq_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// cfq_checker
// Watches the command, capacity and result channels of the circular FIFO
// queue. It keeps its own copy of the ring buffer, works out the results of
// each accepted command and compares every accepted result, field by field,
// with the oldest one still due.
// ----------------------------------------------------------------------------
module cfq_checker
  import cfq_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_valid,
  input  logic                  cfg_ready,
  input  logic [CNT_FLD-1:0]    cfg_data,
  input  logic                  in_tvalid,
  input  logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,
  input  logic                  out_tvalid,
  input  logic                  out_tready,
  input  logic [OUT_DATA_W-1:0] out_tdata,
  input  logic                  out_tuser,
  input  logic                  out_tlast,
  output int                    failures,
  output int                    pending
);

  typedef struct packed {
    logic [WORD_FLD-1:0] word;
    logic                success;
    logic [CNT_FLD-1:0]  used;
    logic [CNT_FLD-1:0]  free;
    logic                full;
    logic                empty;
    logic                last;
  } fifo_result_t;

  fifo_result_t        due_results[$];
  logic [WORD_FLD-1:0] slots[DEPTH];
  int unsigned         head_ptr;
  int unsigned         tail_ptr;
  int unsigned         held;
  int unsigned         capacity;

  function automatic int unsigned wrap_next(input int unsigned ptr);
    return (ptr + 1 >= capacity) ? 0 : ptr + 1;
  endfunction

  // Snapshot the occupancy after the step along with the word
  task automatic log_result(input logic [WORD_FLD-1:0] word, input logic ok,
                            input logic last);
    fifo_result_t r;
    r.word    = ok ? word : '0;
    r.success = ok;
    r.used    = held[CNT_FLD-1:0];
    r.free    = CNT_FLD'(capacity - held);
    r.full    = (held == capacity);
    r.empty   = (held == 0);
    r.last    = last;
    due_results.push_back(r);
  endtask

  task automatic set_capacity(input logic [CNT_FLD-1:0] value);
    if (value == 0) capacity = 1;
    else if (value > DEPTH) capacity = DEPTH;
    else capacity = value;
    head_ptr = 0;
    tail_ptr = 0;
    held     = 0;
  endtask

  task automatic model_command(input logic [CMD_BITS-1:0] cmd,
                               input logic [WORD_FLD-1:0] word,
                               input logic [CNT_FLD-1:0] count);
    int unsigned n;
    int unsigned p;
    case (cmd)
      CMD_PUSH: begin
        if (held >= capacity) begin
          log_result('0, 1'b0, 1'b1);
        end else begin
          slots[tail_ptr] = word;
          tail_ptr = wrap_next(tail_ptr);
          held++;
          log_result('0, 1'b1, 1'b1);
        end
      end
      CMD_POP: begin
        if (held == 0) begin
          log_result('0, 1'b0, 1'b1);
        end else begin
          p = head_ptr;
          head_ptr = wrap_next(head_ptr);
          held--;
          log_result(slots[p], 1'b1, 1'b1);
        end
      end
      CMD_PEEK_HEAD: begin
        if (held == 0) begin
          log_result('0, 1'b0, 1'b1);
        end else begin
          n = (count == 0) ? 1 : count;
          if (n > held) n = held;
          p = head_ptr;
          for (int i = 0; i < n; i++) begin
            log_result(slots[p], 1'b1, i + 1 == n);
            p = wrap_next(p);
          end
        end
      end
      CMD_PEEK_NEW: begin
        if (held == 0) begin
          log_result('0, 1'b0, 1'b1);
        end else begin
          p = ((tail_ptr == 0) ? capacity : tail_ptr) - 1;
          log_result(slots[p], 1'b1, 1'b1);
        end
      end
      CMD_CLEAR: begin
        head_ptr = 0;
        tail_ptr = 0;
        held     = 0;
        log_result('0, 1'b1, 1'b1);
      end
      default: begin
        log_result('0, 1'b0, 1'b1);
      end
    endcase
  endtask

  task automatic check_field(input string name, input logic [WORD_FLD-1:0] want,
                             input logic [WORD_FLD-1:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      failures++;
    end
  endtask

  task automatic check_result();
    fifo_result_t want;
    if (due_results.size() == 0) begin
      $error("unexpected result item: tdata=%h tuser=%b tlast=%b",
             out_tdata, out_tuser, out_tlast);
      failures++;
    end else begin
      want = due_results.pop_front();
      check_field("read_word", want.word, out_tdata[31:0]);
      check_field("success", WORD_FLD'(want.success), WORD_FLD'(out_tuser));
      check_field("used_count", WORD_FLD'(want.used), WORD_FLD'(out_tdata[38:32]));
      check_field("free_count", WORD_FLD'(want.free), WORD_FLD'(out_tdata[45:39]));
      check_field("is_full", WORD_FLD'(want.full), WORD_FLD'(out_tdata[46]));
      check_field("is_empty", WORD_FLD'(want.empty), WORD_FLD'(out_tdata[47]));
      check_field("last_of_run", WORD_FLD'(want.last), WORD_FLD'(out_tlast));
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      due_results.delete();
      failures = 0;
      set_capacity(CNT_FLD'(DEPTH));
    end else begin
      // Results at this edge belong to earlier commands: compare first
      if (out_tvalid && out_tready) check_result();
      if (cfg_valid && cfg_ready) set_capacity(cfg_data);
      if (in_tvalid && in_tready) begin
        model_command(in_tdata[2:0], in_tdata[34:3], in_tdata[41:35]);
      end
    end
    pending <= due_results.size();
  end

endmodule

// File: dv/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Drives commands and capacity writes into the circular FIFO queue: a short
// directed run over empty, full, wrap and odd-command cases, then random
// mixes at several capacities, with random idle bursts on both channels.
// The checker predicts and compares; this module gives the verdict.
// ----------------------------------------------------------------------------
module tb_top;
  import cfq_pkg::*;

  localparam logic [CMD_BITS-1:0] CMD_RSVD_5 = 3'd5;
  localparam logic [CMD_BITS-1:0] CMD_RSVD_6 = 3'd6;
  localparam logic [CMD_BITS-1:0] CMD_RSVD_7 = 3'd7;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CNT_FLD-1:0]    cfg_data;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata;
  logic                  out_tvalid;
  logic                  out_tready;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  out_tuser;
  logic                  out_tlast;
  int                    failures;
  int                    pending;
  bit                    calm;

  circular_fifo_queue_core DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .out_tlast (out_tlast)
  );

  cfq_checker u_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .out_tlast (out_tlast),
    .failures  (failures),
    .pending   (pending)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  initial begin
    #20_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // Result side: random stall bursts, none once calm is set
  initial begin : result_stall
    int hold;
    hold = 0;
    out_tready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (!calm && hold == 0 && $urandom_range(0, 9) == 0) hold = $urandom_range(1, 12);
      if (hold > 0) begin
        out_tready <= 1'b0;
        hold--;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // Called at a falling edge; returns at the falling edge after acceptance
  task automatic issue(input logic [CMD_BITS-1:0] cmd, input logic [WORD_FLD-1:0] word,
                       input logic [CNT_FLD-1:0] count);
    int gap;
    gap = 0;
    if (!calm && $urandom_range(0, 6) == 0) gap = $urandom_range(1, 12);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {6'd0, count, word, cmd};
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
  endtask

  // Hold off until every result is back and the block has settled
  task automatic drain();
    in_tvalid <= 1'b0;
    wait (pending == 0);
    repeat (4) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_capacity(input logic [CNT_FLD-1:0] value);
    drain();
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic random_mix(input int count, input int cap_now);
    int                  roll;
    logic [CNT_FLD-1:0]  run;
    logic [CMD_BITS-1:0] cmd;
    for (int i = 0; i < count; i++) begin
      roll = $urandom_range(0, 99);
      if (roll < 40) cmd = CMD_PUSH;
      else if (roll < 65) cmd = CMD_POP;
      else if (roll < 80) cmd = CMD_PEEK_HEAD;
      else if (roll < 88) cmd = CMD_PEEK_NEW;
      else if (roll < 93) cmd = CMD_CLEAR;
      else begin
        case ($urandom_range(0, 2))
          0:       cmd = CMD_RSVD_5;
          1:       cmd = CMD_RSVD_6;
          default: cmd = CMD_RSVD_7;
        endcase
      end
      roll = $urandom_range(0, 9);
      if (roll == 0) run = '0;
      else if (roll == 1) run = 7'h7f;
      else if (roll == 2) run = CNT_FLD'($urandom_range(0, 127));
      else run = CNT_FLD'($urandom_range(1, cap_now + 1));
      issue(cmd, $urandom, run);
    end
  endtask

  initial begin : stimulus
    calm      = 1'b0;
    rst_n     = 1'b0;
    cfg_valid = 1'b0;
    cfg_data  = '0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Empty queue at reset capacity, then a few words and the odd commands
    issue(CMD_POP, $urandom, 7'd1);
    issue(CMD_PEEK_HEAD, $urandom, 7'd5);
    issue(CMD_PEEK_NEW, $urandom, 7'd1);
    issue(CMD_PUSH, 32'h0000_0000, 7'd0);
    issue(CMD_PUSH, 32'hffff_ffff, 7'h7f);
    issue(CMD_PUSH, $urandom, 7'd0);
    issue(CMD_PEEK_NEW, $urandom, 7'd0);
    issue(CMD_PEEK_HEAD, $urandom, 7'd0);
    issue(CMD_PEEK_HEAD, $urandom, 7'h7f);
    issue(CMD_POP, $urandom, 7'd0);
    issue(CMD_RSVD_5, $urandom, CNT_FLD'($urandom_range(0, 127)));
    issue(CMD_RSVD_6, $urandom, CNT_FLD'($urandom_range(0, 127)));
    issue(CMD_RSVD_7, $urandom, CNT_FLD'($urandom_range(0, 127)));
    issue(CMD_CLEAR, $urandom, 7'd0);
    issue(CMD_POP, $urandom, 7'd0);
    issue(CMD_PUSH, $urandom, 7'd0);

    // Zero clamps to a single slot: full refusal and wrap at once
    write_capacity(7'd0);
    issue(CMD_PUSH, $urandom, 7'd0);
    issue(CMD_PUSH, $urandom, 7'd0);
    issue(CMD_PEEK_NEW, $urandom, 7'd0);
    issue(CMD_PEEK_HEAD, $urandom, 7'd1);
    issue(CMD_POP, $urandom, 7'd0);
    issue(CMD_POP, $urandom, 7'd0);

    // Oversized value clamps to the full memory: fill it and read it all
    write_capacity(7'h7f);
    repeat (65) issue(CMD_PUSH, $urandom, CNT_FLD'($urandom_range(0, 127)));
    issue(CMD_PEEK_HEAD, $urandom, 7'd64);
    issue(CMD_PEEK_NEW, $urandom, 7'd0);
    random_mix(10, 64);

    write_capacity(7'd2);
    random_mix(15, 2);

    write_capacity(CNT_FLD'($urandom_range(3, 12)));
    random_mix(12, 12);
    drain();
    random_mix(12, 12);

    write_capacity(7'd1);
    random_mix(15, 1);

    write_capacity(7'd64);
    calm = 1'b1;
    random_mix(20, 8);

    in_tvalid <= 1'b0;
    wait (pending == 0);
    repeat (16) @(posedge clk);
    if (failures == 0 && pending == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
